@@ design/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-32 decoder.
`timescale 1ns / 1ps

package u8d_pkg;

   localparam int QueueDepth = 4;
   localparam int CodeWidth = 21;

   typedef enum logic [2:0] {
      StOk       = 3'd0,
      StBadLead  = 3'd1,
      StBadCont  = 3'd2,
      StOverlong = 3'd3,
      StTrunc    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      LeadAscii,
      LeadTwo,
      LeadThree,
      LeadFour,
      LeadBad
   } lead_type;

   typedef struct packed {
      lead_type   lead;
      logic       is_cont;
      logic [6:0] lead_bits;
      logic       lead_zero;
      logic [5:0] cont_bits;
      logic       cont_hi_zero2;
      logic       cont_hi_zero3;
      logic       last;
   } beat_type;

   typedef struct packed {
      logic [CodeWidth-1:0] code_point;
      status_type           status;
      logic                 last;
   } result_type;

endpackage

@@ design/u8d_fifo.sv @@
// Small first-in first-out queue used between the decoder stages and at its output.
`timescale 1ns / 1ps

module u8d_fifo
   import u8d_pkg::*;
#(
   parameter int DEPTH = QueueDepth,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full = (count_ff == CountW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/u8d_front.sv @@
// Front stage: classifies each incoming byte as a lead and as a continuation byte.
`timescale 1ns / 1ps

module u8d_front
   import u8d_pkg::*;
(
   input  logic [7:0] data_byte,
   input  logic       string_end,
   output beat_type   beat
);

   always_comb begin
      beat.lead = LeadBad;
      beat.lead_bits = '0;
      if (data_byte < 8'h80) begin
         beat.lead = LeadAscii;
         beat.lead_bits = data_byte[6:0];
      end else if (data_byte >= 8'hC2 && data_byte < 8'hE0) begin
         beat.lead = LeadTwo;
         beat.lead_bits = {2'b00, data_byte[4:0]};
      end else if (data_byte >= 8'hE0 && data_byte < 8'hF0) begin
         beat.lead = LeadThree;
         beat.lead_bits = {3'b000, data_byte[3:0]};
      end else if (data_byte >= 8'hF0 && data_byte < 8'hF8) begin
         beat.lead = LeadFour;
         beat.lead_bits = {4'b0000, data_byte[2:0]};
      end
      beat.lead_zero = (beat.lead_bits == '0);
      beat.is_cont = (data_byte[7:6] == 2'b10);
      beat.cont_bits = data_byte[5:0];
      beat.cont_hi_zero2 = !data_byte[5];
      beat.cont_hi_zero3 = (data_byte[5:4] == 2'b00);
      beat.last = string_end;
   end

endmodule

@@ design/u8d_back.sv @@
// Back stage: runs the sequence state and produces code points and error results.
`timescale 1ns / 1ps

module u8d_back
   import u8d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_empty,
   input  beat_type   in_beat,
   output logic       in_pop,
   input  logic       out_full,
   output logic       out_push,
   output result_type out_result
);

   logic [1:0]           bytes_left_ff, bytes_left_in;
   logic [1:0]           seq_length_ff, seq_length_in;
   logic [CodeWidth-1:0] code_accum_ff, code_accum_in;
   logic                 lead_zero_ff, lead_zero_in;
   logic                 overlong_ff, overlong_in;
   logic                 discarding_ff, discarding_in;
   logic [CodeWidth-1:0] shifted;
   logic [1:0]           left_dec;
   logic                 overlong_now;

   assign in_pop = !in_empty && !out_full;
   assign shifted = {code_accum_ff[CodeWidth-7:0], in_beat.cont_bits};
   assign left_dec = bytes_left_ff - 2'd1;
   assign overlong_now = overlong_ff ||
      ((bytes_left_ff == seq_length_ff) && lead_zero_ff &&
       ((seq_length_ff == 2'd2 && in_beat.cont_hi_zero2) ||
        (seq_length_ff == 2'd3 && in_beat.cont_hi_zero3)));

   always_comb begin
      bytes_left_in = bytes_left_ff;
      seq_length_in = seq_length_ff;
      code_accum_in = code_accum_ff;
      lead_zero_in = lead_zero_ff;
      overlong_in = overlong_ff;
      discarding_in = discarding_ff;
      out_push = 1'b0;
      out_result.code_point = '0;
      out_result.status = StOk;
      out_result.last = in_beat.last;

      if (in_pop) begin
         if (discarding_ff) begin
            if (in_beat.last) begin
               discarding_in = 1'b0;
            end
         end else if (bytes_left_ff == 2'd0) begin
            unique case (in_beat.lead)
               LeadAscii: begin
                  out_push = 1'b1;
                  out_result.code_point = CodeWidth'(in_beat.lead_bits);
               end
               LeadTwo, LeadThree, LeadFour: begin
                  seq_length_in = (in_beat.lead == LeadTwo) ? 2'd1 :
                                  (in_beat.lead == LeadThree) ? 2'd2 : 2'd3;
                  bytes_left_in = seq_length_in;
                  code_accum_in = CodeWidth'(in_beat.lead_bits);
                  lead_zero_in = (in_beat.lead != LeadTwo) && in_beat.lead_zero;
                  overlong_in = 1'b0;
                  if (in_beat.last) begin
                     out_push = 1'b1;
                     out_result.status = StTrunc;
                  end
               end
               default: begin
                  out_push = 1'b1;
                  out_result.status = StBadLead;
               end
            endcase
         end else if (!in_beat.is_cont) begin
            out_push = 1'b1;
            out_result.status = StBadCont;
         end else begin
            code_accum_in = shifted;
            bytes_left_in = left_dec;
            overlong_in = overlong_now;
            if (left_dec == 2'd0) begin
               out_push = 1'b1;
               if (overlong_now) begin
                  out_result.status = StOverlong;
               end else begin
                  out_result.code_point = shifted;
               end
            end else if (in_beat.last) begin
               out_push = 1'b1;
               out_result.status = StTrunc;
            end
         end

         // Any result ends the sequence; an error before the end flag skips the rest.
         if (out_push) begin
            bytes_left_in = '0;
            seq_length_in = '0;
            code_accum_in = '0;
            lead_zero_in = 1'b0;
            overlong_in = 1'b0;
            discarding_in = (out_result.status != StOk) && !in_beat.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         seq_length_ff <= '0;
         code_accum_ff <= '0;
         lead_zero_ff <= 1'b0;
         overlong_ff <= 1'b0;
         discarding_ff <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         seq_length_ff <= seq_length_in;
         code_accum_ff <= code_accum_in;
         lead_zero_ff <= lead_zero_in;
         overlong_ff <= overlong_in;
         discarding_ff <= discarding_in;
      end
   end

endmodule

@@ design/utf8_to_utf32_decoder.sv @@
// Top level of the UTF-8 to UTF-32 decoder.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per beat and returns one result per completed character or
// per error, one beat per cycle sustained while the output queue has room. A byte
// is classified on entry and written to a queue of QUEUE_DEPTH entries; the
// decode stage takes one byte from it each cycle that it holds one and the output
// queue has room, and writes its result to an output queue of the same depth.
// The input side stalls only when both queues have filled behind a held pop.
// After the first error in a string the decoder returns one error result and
// drops the remaining bytes up to and including the one flagged as its end.

module utf8_to_utf32_decoder
   import u8d_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_string_end,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [CodeWidth-1:0] rsp_code_point,
   output logic [2:0]           rsp_status,
   output logic                 rsp_last_of_string
);

   localparam int BeatW = $bits(beat_type);
   localparam int ResultW = $bits(result_type);

   beat_type   front_beat;
   beat_type   mid_beat;
   logic [BeatW-1:0] mid_bits;
   logic       mid_empty;
   logic       mid_pop;
   result_type back_result;
   result_type out_result;
   logic [ResultW-1:0] out_bits;
   logic       out_full;
   logic       out_push;

   u8d_front u_front (
      .data_byte  (req_data_byte),
      .string_end (req_string_end),
      .beat       (front_beat)
   );

   u8d_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (BeatW)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_beat),
      .full      (req_full),
      .pop       (mid_pop),
      .pop_data  (mid_bits),
      .empty     (mid_empty)
   );

   assign mid_beat = beat_type'(mid_bits);

   u8d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_empty   (mid_empty),
      .in_beat    (mid_beat),
      .in_pop     (mid_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_result (back_result)
   );

   u8d_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ResultW)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_bits),
      .empty     (rsp_empty)
   );

   assign out_result = result_type'(out_bits);
   assign rsp_code_point = out_result.code_point;
   assign rsp_status = out_result.status;
   assign rsp_last_of_string = out_result.last;

endmodule
